[sv/lru_page_buffer_pool_unit_macros.svh]
// Assertion helpers shared by the buffer pool RTL.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef LRU_PAGE_BUFFER_POOL_UNIT_MACROS_SVH
`define LRU_PAGE_BUFFER_POOL_UNIT_MACROS_SVH

// Same-cycle implication.
`define LPBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lpbp_pkg.sv]
`timescale 1ns / 1ps
package lpbp_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int PAGE_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int FIDX_W     = 4;
  localparam int REQ_W      = 2;

  // A flush emits at most this many beats; further dirty frames wait.
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP);
  localparam logic [CNT_W-1:0] FLUSH_LAST_CNT = CNT_W'(RESULT_CAP - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PIN   = 2'd0,
    REQ_NEW   = 2'd1,
    REQ_DIRTY = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic flush_step;
  } ctl_cmd_t;

  typedef struct packed {
    req_t req;
    logic out_free;
    logic fl_any;
    logic fl_last;
  } dp_sts_t;

endpackage

[sv/lpbp_ctrl.sv]
`timescale 1ns / 1ps
module lpbp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpbp_pkg::dp_sts_t  sts,
  output lpbp_pkg::ctl_cmd_t cmd
);
  import lpbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    cmd.flush_step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.req)
          REQ_PIN, REQ_NEW: begin
            if (sts.out_free) begin
              cmd.exec   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          REQ_DIRTY: begin
            cmd.exec   = 1'b1;
            state_next = ST_IDLE;
          end
          REQ_FLUSH: begin
            // One writeback beat per cycle while the output register has room.
            if (!sts.fl_any) begin
              state_next = ST_IDLE;
            end else if (sts.out_free) begin
              cmd.flush_step = 1'b1;
              if (sts.fl_last) begin
                state_next = ST_IDLE;
              end
            end
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/lpbp_datapath.sv]
`timescale 1ns / 1ps
module lpbp_datapath #(
  parameter int FRAMES = lpbp_pkg::FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lpbp_pkg::REQ_W-1:0]  req_type,
  input  logic [lpbp_pkg::PAGE_W-1:0] page_number,
  input  logic [lpbp_pkg::SLOT_W-1:0] frame_slot,
  input  lpbp_pkg::ctl_cmd_t          cmd,
  output lpbp_pkg::dp_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpbp_pkg::FIDX_W-1:0] frame_index,
  output logic                        hit,
  output logic                        fetch,
  output logic                        writeback,
  output logic [lpbp_pkg::PAGE_W-1:0] writeback_page,
  output logic                        last
);
  import lpbp_pkg::*;

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  function automatic logic [FW-1:0] lowest_set(input logic [FRAMES-1:0] v);
    logic [FW-1:0] idx;
    idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (v[i]) idx = FW'(i);
    end
    return idx;
  endfunction

  // Request registers, captured when the item is accepted.
  req_t              req_q;
  logic [PAGE_W-1:0] page_q;
  logic [SLOT_W-1:0] slot_q;
  logic [FRAMES-1:0] match_q;

  // Frame table.
  logic [PAGE_W-1:0] tag   [FRAMES];
  logic [FW-1:0]     rank  [FRAMES];
  logic [FRAMES-1:0] valid;
  logic [FRAMES-1:0] dirty;
  logic [FW:0]       count;
  logic [CNT_W-1:0]  fl_cnt;

  logic [FRAMES-1:0] match_in;
  logic [FRAMES-1:0] rank_zero;
  logic [FRAMES-1:0] slot_hit;
  logic [FRAMES-1:0] fl_vec;
  logic              is_hit;
  logic              full;
  logic              exec_pn;
  logic              alloc;
  logic              emit;
  logic [FW-1:0]     hit_f;
  logic [FW-1:0]     vict_f;
  logic [FW-1:0]     tgt_f;
  logic [FW-1:0]     fl_f;
  logic [FW-1:0]     old_rank;
  logic              fl_last;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match_in[i]  = valid[i] && (tag[i] == page_number);
      rank_zero[i] = (rank[i] == '0);
      slot_hit[i]  = (int'(slot_q) == i);
    end
  end

  assign fl_vec   = valid & dirty;
  assign full     = (count == (FW + 1)'(FRAMES));
  assign is_hit   = (req_q == REQ_PIN) && (|match_q);
  assign hit_f    = lowest_set(match_q);
  assign vict_f   = full ? lowest_set(rank_zero) : lowest_set(~valid);
  assign tgt_f    = is_hit ? hit_f : vict_f;
  assign old_rank = rank[tgt_f];
  assign fl_f     = lowest_set(fl_vec);
  // Clearing the lowest set bit tells whether another dirty frame follows.
  assign fl_last  = !(|(fl_vec & (fl_vec - 1'b1))) || (fl_cnt == FLUSH_LAST_CNT);
  assign exec_pn  = cmd.exec && ((req_q == REQ_PIN) || (req_q == REQ_NEW));
  assign alloc    = exec_pn && !is_hit;
  assign emit     = exec_pn || cmd.flush_step;

  assign sts.req      = req_q;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.fl_any   = |fl_vec;
  assign sts.fl_last  = fl_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_t'(req_type);
      page_q  <= page_number;
      slot_q  <= frame_slot;
      match_q <= match_in;
    end
    if (alloc) begin
      tag[tgt_f] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      dirty     <= '0;
      count     <= '0;
      fl_cnt    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        fl_cnt <= '0;
      end
      if (cmd.exec && (req_q == REQ_DIRTY)) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (slot_hit[i] && valid[i]) dirty[i] <= 1'b1;
        end
      end
      if (exec_pn) begin
        if (is_hit || full) begin
          // Move the frame to the top; frames above its old rank step down.
          for (int j = 0; j < FRAMES; j++) begin
            if ((j != int'(tgt_f)) && valid[j] && (rank[j] > old_rank)) begin
              rank[j] <= rank[j] - 1'b1;
            end
          end
          rank[tgt_f] <= FW'(count - 1'b1);
          if (!is_hit) begin
            dirty[tgt_f] <= (req_q == REQ_NEW);
          end
        end else begin
          rank[tgt_f]  <= FW'(count);
          valid[tgt_f] <= 1'b1;
          dirty[tgt_f] <= (req_q == REQ_NEW);
          count        <= count + 1'b1;
        end
      end
      if (cmd.flush_step) begin
        dirty[fl_f] <= 1'b0;
        fl_cnt      <= fl_cnt + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_step) begin
      frame_index    <= FIDX_W'(fl_f);
      hit            <= 1'b0;
      fetch          <= 1'b0;
      writeback      <= 1'b1;
      writeback_page <= tag[fl_f];
      last           <= fl_last;
    end else if (exec_pn) begin
      frame_index    <= FIDX_W'(tgt_f);
      hit            <= is_hit;
      fetch          <= (req_q == REQ_PIN) && !is_hit;
      writeback      <= alloc && full && dirty[tgt_f];
      writeback_page <= (alloc && full && dirty[tgt_f]) ? tag[tgt_f] : '0;
      last           <= 1'b1;
    end
  end

endmodule

[sv/lru_page_buffer_pool_unit.sv]
`timescale 1ns / 1ps
// Fully associative page frame pool with least recently used replacement.
// Requests arrive on the input channel (in_valid/in_ready) as req_type,
// page_number and frame_slot: pin, new page, mark dirty, or flush.
// Results leave on the output channel (out_valid/out_ready), one beat each.
// A pin or new page gives one beat with last set; mark dirty gives none;
// a flush gives one writeback beat per dirty frame, lowest frame first,
// with last on the final beat, and up to 16 beats per flush.
// For a pin or new page, the accept edge registers the request together
// with the parallel tag compare; once the output register has room, the
// table is updated and the output register loaded. Requests are served
// one at a time: a new request is not accepted until the last is done.
// The next request is accepted while a result still waits.
// When the receiver stalls, the output register holds its beat and any
// further result waits in the controller until the register frees up.
// Reset empties every frame and clears dirty bits and recency ranks; page
// tags are not cleared and are only read for frames that are valid.
`include "lru_page_buffer_pool_unit_macros.svh"
module lru_page_buffer_pool_unit #(
  parameter int FRAMES = lpbp_pkg::FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpbp_pkg::REQ_W-1:0]  req_type,
  input  logic [lpbp_pkg::PAGE_W-1:0] page_number,
  input  logic [lpbp_pkg::SLOT_W-1:0] frame_slot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpbp_pkg::FIDX_W-1:0] frame_index,
  output logic                        hit,
  output logic                        fetch,
  output logic                        writeback,
  output logic [lpbp_pkg::PAGE_W-1:0] writeback_page,
  output logic                        last
);
  import lpbp_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  lpbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpbp_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .page_number    (page_number),
    .frame_slot     (frame_slot),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_index    (frame_index),
    .hit            (hit),
    .fetch          (fetch),
    .writeback      (writeback),
    .writeback_page (writeback_page),
    .last           (last)
  );

  `LPBP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted twice in a row")
  `LPBP_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.exec, cmd.flush_step}), "commands overlap")
  `LPBP_ASSERT_IMP(a_flush_room, cmd.flush_step, sts.out_free && sts.fl_any, "flush beat without room or work")
  `LPBP_ASSERT_NEXT(a_flush_beat, cmd.flush_step, out_valid && writeback && !hit && !fetch, "flush beat malformed")

endmodule
